// ===== rtl/variable_coeff_five_point_operator_assert.svh =====
// Assertion macros for the five-point operator RTL.
// Used by the top level only; no other dependencies.
`ifndef VARIABLE_COEFF_FIVE_POINT_OPERATOR_ASSERT_SVH
`define VARIABLE_COEFF_FIVE_POINT_OPERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define VCFPO_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vcfpo: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define VCFPO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vcfpo: next-cycle check failed");

`endif

// ===== rtl/vcfpo_pkg.sv =====
// Shared types and constants for the five-point operator.
// No dependencies; imported by vcfpo_mul and the top level.
`timescale 1ns / 1ps

package vcfpo_pkg;

    // fixed field widths
    localparam int W_W        = 40;   // grid values, signed
    localparam int STEP_W     = 24;   // mesh steps, unsigned Q0.24
    localparam int INV_W      = 32;   // reciprocal squared steps, Q24.8
    localparam int OUT_W      = 64;   // result, signed
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // operand chunk for the pipelined multipliers
    localparam int MUL_CHUNK  = 32;

    // k = 4 + x with x = -1 + row*hx  ->  3 + row*hx
    localparam int K_OFFSET   = 3;
    // x + y = row*hx + col*hy - 3
    localparam int ORIGIN_SUM = 3;

    // register reset values
    localparam int                 LAST_ROW_RST = 500;
    localparam int                 LAST_COL_RST = 1000;
    localparam logic [STEP_W-1:0]  STEP_X_RST   = 24'd100663;
    localparam logic [STEP_W-1:0]  STEP_Y_RST   = 24'd67109;
    localparam logic [INV_W-1:0]   INV_X_RST    = 32'd7111111;
    localparam logic [INV_W-1:0]   INV_Y_RST    = 32'd16000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAST_ROW = 3'd0,
        CFG_LAST_COL = 3'd1,
        CFG_STEP_X   = 3'd2,
        CFG_STEP_Y   = 3'd3,
        CFG_INV_X    = 3'd4,
        CFG_INV_Y    = 3'd5
    } cfg_reg_t;

endpackage

// ===== rtl/vcfpo_mul.sv =====
// Three-stage signed multiplier: chunk products, row sums, final sum.
// Depends on vcfpo_pkg (MUL_CHUNK).
`timescale 1ns / 1ps

module vcfpo_mul #(
    parameter int AW = 40,
    parameter int BW = 40
) (
    input  logic                     aclk,
    input  logic [2:0]               en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);
    import vcfpo_pkg::*;

    localparam int CH = MUL_CHUNK;
    localparam int NA = (AW + CH - 1) / CH;
    localparam int NB = (BW + CH - 1) / CH;
    localparam int PW = AW + BW;
    localparam int QW = 2 * CH + 2;

    logic signed [NA*CH-1:0] a_ext;
    logic signed [NB*CH-1:0] b_ext;
    logic signed [CH:0]      a_ch [NA];
    logic signed [CH:0]      b_ch [NB];
    logic signed [QW-1:0]    pp_reg [NA][NB];
    logic [PW-1:0]           row_next [NA];
    logic [PW-1:0]           row_reg  [NA];
    logic [PW-1:0]           p_next;
    logic [PW-1:0]           p_reg;

    assign a_ext = (NA*CH)'(a);
    assign b_ext = (NB*CH)'(b);

    // top chunk carries the sign, lower chunks are zero-extended
    for (genvar gi = 0; gi < NA; gi++) begin : g_ach
        if (gi == NA - 1) begin : g_top
            assign a_ch[gi] = {a_ext[NA*CH-1], a_ext[gi*CH +: CH]};
        end else begin : g_low
            assign a_ch[gi] = {1'b0, a_ext[gi*CH +: CH]};
        end
    end
    for (genvar gj = 0; gj < NB; gj++) begin : g_bch
        if (gj == NB - 1) begin : g_top
            assign b_ch[gj] = {b_ext[NB*CH-1], b_ext[gj*CH +: CH]};
        end else begin : g_low
            assign b_ch[gj] = {1'b0, b_ext[gj*CH +: CH]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= a_ch[i] * b_ch[j];
                end
            end
        end
    end

    // modulo 2^PW sums; the full product fits PW bits
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (j * CH));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            row_reg <= row_next;
        end
    end

    always_comb begin
        p_next = '0;
        for (int i = 0; i < NA; i++) begin
            p_next = p_next + (row_reg[i] << (i * CH));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            p_reg <= p_next;
        end
    end

    assign p = $signed(p_reg);

endmodule

// ===== rtl/variable_coeff_five_point_operator.sv =====
// Five-point variable-coefficient operator -div(k grad w) + q w, 12-stage pipeline.
// Depends on vcfpo_pkg, vcfpo_mul and variable_coeff_five_point_operator_assert.svh.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+------------------------------------
//   s_  input | in        | s_valid / s_ready   | s_row, s_col, s_w_center .. s_w_up
//   m_  result| out       | m_valid / m_ready   | m_op_result, m_on_boundary, m_saturated
//   cfg_ write| in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle sustained while m_ready is high; 12 register stages, so a
// transaction accepted into stage 1 moves through stages 2 to 11 into the result register.
// Two 3-stage multiplier banks plus decode, add and rounding stages make up the pipeline.
// Every stage holds a valid bit; a stage loads when it is empty or its successor moves,
// so bubbles are squeezed out while m_ready is low and nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears the valid bits and loads the register defaults.
// cfg_ready is always high; registers must only change while the pipeline is empty.
`timescale 1ns / 1ps
`include "variable_coeff_five_point_operator_assert.svh"

module variable_coeff_five_point_operator #(
    parameter int FRAC_BITS  = 24,
    parameter int INDEX_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vcfpo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vcfpo_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [INDEX_BITS-1:0]                  s_row,
    input  logic [INDEX_BITS-1:0]                  s_col,
    input  logic signed [vcfpo_pkg::W_W-1:0]       s_w_center,
    input  logic signed [vcfpo_pkg::W_W-1:0]       s_w_left,
    input  logic signed [vcfpo_pkg::W_W-1:0]       s_w_right,
    input  logic signed [vcfpo_pkg::W_W-1:0]       s_w_down,
    input  logic signed [vcfpo_pkg::W_W-1:0]       s_w_up,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [vcfpo_pkg::OUT_W-1:0]     m_op_result,
    output logic                                   m_on_boundary,
    output logic                                   m_saturated
);
    import vcfpo_pkg::*;

    // ------------------------------------------------------------------
    // Widths. All intermediate values are exact; nothing wraps before the
    // final saturation.
    // ------------------------------------------------------------------
    localparam int NST  = 12;
    localparam int RXW  = INDEX_BITS + STEP_W;                  // row*hx
    localparam int KW   = ((RXW > FRAC_BITS + 2) ? RXW : FRAC_BITS + 2) + 2;  // 2k, unsigned
    localparam int SSW  = ((RXW + 1 > FRAC_BITS + 2) ? RXW + 1 : FRAC_BITS + 2) + 1; // x+y
    localparam int D1W  = W_W + 1;                              // wr - wl
    localparam int D2W  = W_W + 3;                              // second differences
    localparam int P1W  = KW + 1 + D2W;
    localparam int P2W  = STEP_W + 1 + D1W;
    localparam int TW   = ((P1W > P2W) ? P1W : P2W) + 1;
    localparam int P5W  = TW + INV_W + 1;
    localparam int P6W  = P1W + INV_W + 1;
    localparam int SUMW = ((P5W > P6W) ? P5W : P6W) + 1;
    localparam int NW   = SUMW + 1;
    localparam int DSH  = FRAC_BITS + 9;
    localparam int DW   = NW - DSH;
    localparam int P4W  = 2 * SSW;
    localparam int P7W  = P4W + W_W;
    localparam int QNW  = P7W + 1;
    localparam int QSH  = 2 * FRAC_BITS;
    localparam int QW   = QNW - QSH;
    localparam int RW   = ((DW > QW) ? DW : QW) + 1;

    localparam logic [KW-1:0]  KX_BASE  = KW'(K_OFFSET) << FRAC_BITS;
    localparam logic [SSW-1:0] ORG_BASE = SSW'(ORIGIN_SUM) << FRAC_BITS;
    localparam logic [NW-1:0]  D_HALF   = NW'(1) << (DSH - 1);
    localparam logic [QNW-1:0] Q_HALF   = QNW'(1) << (QSH - 1);
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [INDEX_BITS-1:0] last_row_reg;
    logic [INDEX_BITS-1:0] last_col_reg;
    logic [STEP_W-1:0]     step_x_reg;
    logic [STEP_W-1:0]     step_y_reg;
    logic [INV_W-1:0]      inv_x_reg;
    logic [INV_W-1:0]      inv_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_row_reg <= INDEX_BITS'(LAST_ROW_RST);
            last_col_reg <= INDEX_BITS'(LAST_COL_RST);
            step_x_reg   <= STEP_X_RST;
            step_y_reg   <= STEP_Y_RST;
            inv_x_reg    <= INV_X_RST;
            inv_y_reg    <= INV_Y_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LAST_ROW: last_row_reg <= cfg_data[INDEX_BITS-1:0];
                CFG_LAST_COL: last_col_reg <= cfg_data[INDEX_BITS-1:0];
                CFG_STEP_X:   step_x_reg   <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:   step_y_reg   <= cfg_data[STEP_W-1:0];
                CFG_INV_X:    inv_x_reg    <= cfg_data[INV_W-1:0];
                CFG_INV_Y:    inv_y_reg    <= cfg_data[INV_W-1:0];
                default: ;   // writes past the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage moves when it or any stage after it is
    // empty, or when the result register is being drained.
    // ------------------------------------------------------------------
    logic [NST:1] v_reg;
    logic [NST:1] stage_en;

    for (genvar gs = 1; gs <= NST; gs++) begin : g_en
        assign stage_en[gs] = m_ready | ~(&v_reg[NST:gs]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (stage_en[1]) begin
                v_reg[1] <= s_valid;
            end
            for (int i = 2; i <= NST; i++) begin
                if (stage_en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_ready = stage_en[1];
    assign m_valid = v_reg[NST];

    // centre value and boundary flag ride along to the result stage
    logic signed [W_W-1:0] wc_pipe_reg  [1:NST-1];
    logic                  bnd_pipe_reg [1:NST-1];

    // ------------------------------------------------------------------
    // Stage 1: boundary decode, neighbor drop, differences, index*step
    // ------------------------------------------------------------------
    logic                  bnd_next;
    logic signed [W_W-1:0] wl_m, wr_m, wd_m, wu_m;
    logic signed [D1W-1:0] dx1_next, dx1_s1_reg, dx1_s2_reg;
    logic signed [D2W-1:0] dx2_next, dx2_s1_reg, dx2_s2_reg;
    logic signed [D2W-1:0] dy2_next, dy2_s1_reg, dy2_s2_reg;
    logic [RXW-1:0]        rx_next, rx_reg;
    logic [RXW-1:0]        cy_next, cy_reg;

    always_comb begin
        bnd_next = (s_row == '0) || (s_row >= last_row_reg) ||
                   (s_col == '0) || (s_col >= last_col_reg);
        // a neighbor that sits on the boundary contributes zero
        wl_m = (s_row == INDEX_BITS'(1))                     ? '0 : s_w_left;
        wr_m = (s_row == last_row_reg - INDEX_BITS'(1))      ? '0 : s_w_right;
        wd_m = (s_col == INDEX_BITS'(1))                     ? '0 : s_w_down;
        wu_m = (s_col == last_col_reg - INDEX_BITS'(1))      ? '0 : s_w_up;
        dx1_next = D1W'(wr_m) - D1W'(wl_m);
        dx2_next = D2W'(wr_m) + D2W'(wl_m) - (D2W'(s_w_center) <<< 1);
        dy2_next = D2W'(wu_m) + D2W'(wd_m) - (D2W'(s_w_center) <<< 1);
        rx_next  = RXW'(s_row) * RXW'(step_x_reg);
        cy_next  = RXW'(s_col) * RXW'(step_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            dx1_s1_reg      <= dx1_next;
            dx2_s1_reg      <= dx2_next;
            dy2_s1_reg      <= dy2_next;
            rx_reg          <= rx_next;
            cy_reg          <= cy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            wc_pipe_reg[1]  <= s_w_center;
            bnd_pipe_reg[1] <= bnd_next;
        end
        for (int i = 2; i <= NST - 1; i++) begin
            if (stage_en[i]) begin
                wc_pipe_reg[i]  <= wc_pipe_reg[i-1];
                bnd_pipe_reg[i] <= bnd_pipe_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: 2k at the point (Q.F) and x+y (Q.F)
    // ------------------------------------------------------------------
    logic [KW-1:0]  kx2_next, kx2_reg;
    logic [SSW-1:0] s_next, s_reg;

    always_comb begin
        kx2_next = (KX_BASE + KW'(rx_reg)) << 1;
        s_next   = SSW'(rx_reg) + SSW'(cy_reg) - ORG_BASE;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            kx2_reg    <= kx2_next;
            s_reg      <= s_next;
            dx1_s2_reg <= dx1_s1_reg;
            dx2_s2_reg <= dx2_s1_reg;
            dy2_s2_reg <= dy2_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3-5: first multiplier bank.
    // Face coefficients 2k -/+ hx give
    //   a_hi*dr - a_lo*dl = 2k*(wr - 2wc + wl) + hx*(wr - wl)
    // ------------------------------------------------------------------
    logic signed [P1W-1:0] p1, p3;
    logic signed [P2W-1:0] p2;
    logic signed [P4W-1:0] p4;

    vcfpo_mul #(.AW(KW + 1), .BW(D2W)) u_mul_kdx (
        .aclk (aclk), .en (stage_en[5:3]),
        .a ({1'b0, kx2_reg}), .b (dx2_s2_reg), .p (p1)
    );

    vcfpo_mul #(.AW(STEP_W + 1), .BW(D1W)) u_mul_hdx (
        .aclk (aclk), .en (stage_en[5:3]),
        .a ({1'b0, step_x_reg}), .b (dx1_s2_reg), .p (p2)
    );

    vcfpo_mul #(.AW(KW + 1), .BW(D2W)) u_mul_kdy (
        .aclk (aclk), .en (stage_en[5:3]),
        .a ({1'b0, kx2_reg}), .b (dy2_s2_reg), .p (p3)
    );

    vcfpo_mul #(.AW(SSW), .BW(SSW)) u_mul_q (
        .aclk (aclk), .en (stage_en[5:3]),
        .a ($signed(s_reg)), .b ($signed(s_reg)), .p (p4)
    );

    // ------------------------------------------------------------------
    // Stage 6: combine the x terms; align the y term and q
    // ------------------------------------------------------------------
    logic signed [TW-1:0]  tx_next, tx_reg;
    logic signed [P1W-1:0] ky_reg;
    logic signed [P4W-1:0] qv_reg;

    assign tx_next = TW'(p1) + TW'(p2);

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            tx_reg <= tx_next;
            ky_reg <= p3;
            qv_reg <= p4;
        end
    end

    // ------------------------------------------------------------------
    // Stages 7-9: second multiplier bank (reciprocal steps, q*w)
    // ------------------------------------------------------------------
    logic signed [P5W-1:0] p5;
    logic signed [P6W-1:0] p6;
    logic signed [P7W-1:0] p7;

    vcfpo_mul #(.AW(TW), .BW(INV_W + 1)) u_mul_ix (
        .aclk (aclk), .en (stage_en[9:7]),
        .a (tx_reg), .b ({1'b0, inv_x_reg}), .p (p5)
    );

    vcfpo_mul #(.AW(P1W), .BW(INV_W + 1)) u_mul_iy (
        .aclk (aclk), .en (stage_en[9:7]),
        .a (ky_reg), .b ({1'b0, inv_y_reg}), .p (p6)
    );

    vcfpo_mul #(.AW(P4W), .BW(W_W)) u_mul_qw (
        .aclk (aclk), .en (stage_en[9:7]),
        .a (qv_reg), .b (wc_pipe_reg[6]), .p (p7)
    );

    // ------------------------------------------------------------------
    // Stage 10: diffusion sum; q*w rounded half up to Q.F
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] sum_next, sum_reg;
    logic [QNW-1:0]         qn;
    logic signed [QW-1:0]   qw_s10_reg, qw_s11_reg;

    always_comb begin
        sum_next = SUMW'(p5) + SUMW'(p6);
        qn       = QNW'(p7) + Q_HALF;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[10]) begin
            sum_reg    <= sum_next;
            qw_s10_reg <= $signed(qn[QNW-1:QSH]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: negate and round the diffusion sum to Q.F
    // ------------------------------------------------------------------
    logic [NW-1:0]        nsum;
    logic signed [DW-1:0] diff_reg;

    assign nsum = D_HALF - NW'(sum_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[11]) begin
            diff_reg   <= $signed(nsum[NW-1:DSH]);
            qw_s11_reg <= qw_s10_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: final add, saturation, boundary bypass, result register
    // ------------------------------------------------------------------
    logic signed [RW-1:0]    res;
    logic                    ovf;
    logic [OUT_W-1:0]        res_sat;
    logic [OUT_W-1:0]        op_result_next;
    logic                    saturated_next;
    logic [OUT_W-1:0]        op_result_reg;
    logic                    on_boundary_reg;
    logic                    saturated_reg;

    always_comb begin
        res = RW'(diff_reg) + RW'(qw_s11_reg);
        // in range only if every bit from the top down to OUT_W-1 agrees
        ovf = !((&res[RW-1:OUT_W-1]) || !(|res[RW-1:OUT_W-1]));
        res_sat = ovf ? (res[RW-1] ? OUT_MIN : OUT_MAX) : res[OUT_W-1:0];
        if (bnd_pipe_reg[NST-1]) begin
            op_result_next = OUT_W'(wc_pipe_reg[NST-1]);
            saturated_next = 1'b0;
        end else begin
            op_result_next = res_sat;
            saturated_next = ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NST]) begin
            op_result_reg   <= op_result_next;
            on_boundary_reg <= bnd_pipe_reg[NST-1];
            saturated_reg   <= saturated_next;
        end
    end

    assign m_op_result   = $signed(op_result_reg);
    assign m_on_boundary = on_boundary_reg;
    assign m_saturated   = saturated_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `VCFPO_ASSERT_SAME(a_ready_when_out_empty, aclk, aresetn, !m_valid, s_ready)
    `VCFPO_ASSERT_NEXT(a_accept_fills_stage1, aclk, aresetn, s_valid && s_ready, v_reg[1])
    `VCFPO_ASSERT_SAME(a_boundary_not_clipped, aclk, aresetn, m_valid && m_on_boundary,
        !m_saturated)
    `VCFPO_ASSERT_SAME(a_clip_at_limit, aclk, aresetn, m_valid && m_saturated,
        (op_result_reg == OUT_MAX) || (op_result_reg == OUT_MIN))

endmodule
